FILE: hw/rtl/dtwa_pkg.sv
// ----------------------------------------------------------------------------
// Device table package
// Shared constants and codes for the device table with aging.
// ----------------------------------------------------------------------------
package dtwa_pkg;

    localparam int TableDepth = 32;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam logic [15:0] TimeoutReset = 16'd60;

    typedef enum logic [1:0] {
        FUNC_REPORT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ADDED    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
        logic [31:0] seen;
    } entry_t;

endpackage

FILE: hw/rtl/device_table_with_aging_unit.sv
// ----------------------------------------------------------------------------
// Device table with aging
// Keeps discovered devices in arrival order, ages them out on reports.
// ----------------------------------------------------------------------------
// One operation is taken at a time while busy is low. A report walks the whole
// table through the entry memory, reading each entry and writing it back only
// if it has not expired, then searches the kept entries for the address unless
// the table stays full. Lookup searches the table, read fetches one entry and
// clear empties the table. Each result is shown for exactly one cycle with done
// high and cannot be held off.
module device_table_with_aging_unit
    import dtwa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic [1:0]        func,
    input  logic [47:0]       mac_addr,
    input  logic [31:0]       ip_addr,
    input  logic [4:0]        entry_index,
    input  logic [31:0]       now_seconds,
    output logic              done,
    output logic [1:0]        result_status,
    output logic [4:0]        result_index,
    output logic [31:0]       result_ip,
    output logic [5:0]        live_count
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_AGE   = 7'b0000010,
        S_AGEW  = 7'b0000100,
        S_FIND  = 7'b0001000,
        S_FINDW = 7'b0010000,
        S_RDW   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    entry_t mem [TableDepth];

    state_t          state_reg, state_next;
    logic [15:0]     timeout_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] rd_reg, rd_next;
    logic [CntW-1:0] wr_reg, wr_next;
    func_t           func_reg;
    logic [47:0]     mac_reg;
    logic [31:0]     ip_reg;
    logic [4:0]      idx_reg;
    logic [31:0]     now_reg;
    entry_t          rdata_reg;
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic [IdxW-1:0] raddr;
    logic            re;
    logic [32:0]     limit;
    logic [1:0]      st_reg, st_next;
    logic [4:0]      ri_reg, ri_next;
    logic [31:0]     rip_reg, rip_next;
    logic            done_reg;

    assign busy = (state_reg != S_IDLE);
    assign limit = {1'b0, rdata_reg.seen} + {17'd0, timeout_reg};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg <= func_t'(func);
            mac_reg  <= mac_addr;
            ip_reg   <= ip_addr;
            idx_reg  <= entry_index;
            now_reg  <= now_seconds;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        st_next    = st_reg;
        ri_next    = ri_reg;
        rip_next   = rip_reg;
        we         = 1'b0;
        waddr      = wr_reg[IdxW-1:0];
        wdata      = rdata_reg;
        re         = 1'b0;
        raddr      = rd_reg[IdxW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                rd_next = '0;
                wr_next = '0;
                st_next = ST_OK;
                ri_next = '0;
                rip_next = '0;
                if (start)
                begin
                    unique case (func_t'(func))
                        FUNC_REPORT: state_next = S_AGE;
                        FUNC_LOOKUP: state_next = S_FIND;
                        FUNC_READ:
                        begin
                            re = 1'b1;
                            raddr = entry_index[IdxW-1:0];
                            state_next = S_RDW;
                        end
                        default:
                        begin
                            count_next = '0;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_AGE:
            begin
                if (rd_reg < count_reg)
                begin
                    re = 1'b1;
                    state_next = S_AGEW;
                end
                else
                begin
                    count_next = wr_reg;
                    rd_next = '0;
                    if (wr_reg >= CntW'(TableDepth))
                    begin
                        st_next = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_FIND;
                    end
                end
            end
            S_AGEW:
            begin
                rd_next = rd_reg + 1'b1;
                if ({1'b0, now_reg} <= limit)
                begin
                    we = 1'b1;
                    wr_next = wr_reg + 1'b1;
                end
                state_next = S_AGE;
            end
            S_FIND:
            begin
                if (rd_reg < count_reg)
                begin
                    re = 1'b1;
                    state_next = S_FINDW;
                end
                else
                begin
                    state_next = S_OUT;
                    if (func_reg == FUNC_LOOKUP)
                    begin
                        st_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        we = 1'b1;
                        waddr = count_reg[IdxW-1:0];
                        wdata = '{mac: mac_reg, ip: ip_reg, seen: now_reg};
                        st_next = ST_ADDED;
                        ri_next = 5'(count_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_FINDW:
            begin
                if (rdata_reg.mac == mac_reg)
                begin
                    state_next = S_OUT;
                    st_next = ST_OK;
                    ri_next = 5'(rd_reg);
                    if (func_reg == FUNC_REPORT)
                    begin
                        we = 1'b1;
                        waddr = rd_reg[IdxW-1:0];
                        wdata = rdata_reg;
                        wdata.seen = now_reg;
                    end
                end
                else
                begin
                    rd_next = rd_reg + 1'b1;
                    state_next = S_FIND;
                end
            end
            S_RDW:
            begin
                state_next = S_OUT;
                if ({1'b0, idx_reg} < count_reg)
                begin
                    st_next = ST_OK;
                    ri_next = idx_reg;
                    rip_next = rdata_reg.ip;
                end
                else
                begin
                    st_next = ST_NOTFOUND;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            timeout_reg <= TimeoutReset;
            count_reg   <= '0;
            rd_reg      <= '0;
            wr_reg      <= '0;
            st_reg      <= '0;
            ri_reg      <= '0;
            rip_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            st_reg    <= st_next;
            ri_reg    <= ri_next;
            rip_reg   <= rip_next;
            done_reg  <= (state_reg == S_OUT);
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    assign done          = done_reg;
    assign result_status = st_reg;
    assign result_index  = ri_reg;
    assign result_ip     = rip_reg;
    assign live_count    = 6'(count_reg);

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(TableDepth))
        else $error("entry count beyond table depth");
    a_wr_le_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AGE) |-> (wr_reg <= rd_reg))
        else $error("compaction write pointer ahead of read pointer");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
`endif

endmodule
